// ===== hw/rtl/isl_pkg.sv =====
// ----------------------------------------------------------------------------
// isl_pkg: shared definitions of the indexed sequence list
// Request modes, result status codes, channel layout constants and the
// control word that the sequencer hands to every cell of the chain.
// ----------------------------------------------------------------------------
package isl_pkg;

   // Default sizes of the list.
   localparam int DefaultCapacity  = 16;
   localparam int DefaultDataWidth = 32;

   // Field widths of the request and result items.
   localparam int ModeBits   = 4;
   localparam int PosBits    = 5;
   localparam int ValueBits  = 32;
   localparam int StatusBits = 2;
   localparam int CountBits  = 5;

   // Channel widths, padded to whole bytes.
   localparam int ReqDataBits = 40;
   localparam int RspDataBits = 104;

   // Request modes.
   localparam logic [ModeBits-1:0] MODE_PUSH_BACK  = 4'd0;
   localparam logic [ModeBits-1:0] MODE_PUSH_FRONT = 4'd1;
   localparam logic [ModeBits-1:0] MODE_INSERT     = 4'd2;
   localparam logic [ModeBits-1:0] MODE_POP_BACK   = 4'd3;
   localparam logic [ModeBits-1:0] MODE_POP_FRONT  = 4'd4;
   localparam logic [ModeBits-1:0] MODE_REMOVE     = 4'd5;
   localparam logic [ModeBits-1:0] MODE_READ       = 4'd6;
   localparam logic [ModeBits-1:0] MODE_WRITE      = 4'd7;
   localparam logic [ModeBits-1:0] MODE_CLEAR      = 4'd8;

   // Result status codes.
   localparam logic [StatusBits-1:0] STATUS_OK    = 2'd0;
   localparam logic [StatusBits-1:0] STATUS_RANGE = 2'd1;
   localparam logic [StatusBits-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [StatusBits-1:0] STATUS_FULL  = 2'd3;

   // What each cell does with its element on an accepted item.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_WRITE
   } cell_op_type;

   // Control word broadcast to the cell chain.
   typedef struct packed {
      cell_op_type op;     // element update
      logic        load;   // copy next elements into the readout line
      logic        shift;  // move the readout line one cell toward the front
   } cell_ctrl_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SWEEP,
      SEQ_DONE
   } seq_state_type;

endpackage

// ===== hw/rtl/isl_cell.sv =====
// ----------------------------------------------------------------------------
// isl_cell: one place of the list
// Holds one element and one readout tap. On insert, remove or write the
// element takes its left neighbor, its right neighbor or the new value; the
// tap line copies all elements and then walks them toward the front.
// ----------------------------------------------------------------------------
module isl_cell #(
   parameter int DATA_WIDTH = isl_pkg::DefaultDataWidth,
   parameter int CNT_WIDTH  = 5,
   parameter int INDEX      = 0
) (
   input  logic                   clock,
   input  isl_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_WIDTH-1:0]   pos,
   input  logic [DATA_WIDTH-1:0]  value,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   input  logic [DATA_WIDTH-1:0]  right_tap,
   output logic [DATA_WIDTH-1:0]  data,
   output logic [DATA_WIDTH-1:0]  tap
);
   import isl_pkg::*;

   localparam logic [CNT_WIDTH-1:0] Idx = CNT_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [DATA_WIDTH-1:0] tap_ff, tap_in;

   // Element update for the accepted item.
   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (Idx == pos) begin
               data_in = value;
            end else if (Idx > pos) begin
               data_in = left_data;
            end
         end
         CELL_REMOVE: begin
            if (Idx >= pos) begin
               data_in = right_data;
            end
         end
         CELL_WRITE: begin
            if (Idx == pos) begin
               data_in = value;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Readout tap: loaded with the new element, then shifted toward the front.
   always_comb begin
      if (ctrl.load) begin
         tap_in = data_in;
      end else if (ctrl.shift) begin
         tap_in = right_tap;
      end else begin
         tap_in = tap_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tap_ff  <= tap_in;
   end

   assign data = data_ff;
   assign tap  = tap_ff;

endmodule

// ===== hw/rtl/isl_ctrl.sv =====
// ----------------------------------------------------------------------------
// isl_ctrl: request decoder and sequencer of the list
// Checks each request against the element count, drives the cell chain,
// collects front, back and read values from the readout line and holds the
// result item in an output register.
// ----------------------------------------------------------------------------
module isl_ctrl #(
   parameter int CAPACITY   = isl_pkg::DefaultCapacity,
   parameter int DATA_WIDTH = isl_pkg::DefaultDataWidth,
   parameter int CNT_WIDTH  = $clog2(CAPACITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [isl_pkg::ReqDataBits-1:0]  req_tdata,
   input  logic [isl_pkg::ModeBits-1:0]     req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [isl_pkg::RspDataBits-1:0]  rsp_tdata,
   input  logic [DATA_WIDTH-1:0]            front_tap,
   output isl_pkg::cell_ctrl_type           cell_ctrl,
   output logic [CNT_WIDTH-1:0]             cell_pos,
   output logic [DATA_WIDTH-1:0]            cell_value
);
   import isl_pkg::*;

   localparam logic [CNT_WIDTH-1:0] Cap = CNT_WIDTH'(CAPACITY);
   localparam int WideBits = CNT_WIDTH + PosBits;

   // Request fields.
   logic [PosBits-1:0]          req_position;
   logic [ValueBits-1:0]        req_value;
   logic [DATA_WIDTH+31:0]      value_ext;
   logic [WideBits-1:0]         pos_wide;
   logic [WideBits-1:0]         count_wide;
   logic                        accept;

   // Decoded request.
   logic [StatusBits-1:0]       dec_status;
   cell_op_type                 dec_op;
   logic [CNT_WIDTH-1:0]        dec_pos;
   logic [CNT_WIDTH-1:0]        dec_count;
   logic                        dec_read;

   // Sequencer and result registers.
   seq_state_type               state_ff, state_in;
   logic [CNT_WIDTH-1:0]        count_ff, count_in;
   logic [CNT_WIDTH-1:0]        step_ff, step_in;
   logic [CNT_WIDTH-1:0]        last_ff, last_in;
   logic [CNT_WIDTH-1:0]        pos_ff, pos_in;
   logic                        read_ff, read_in;
   logic [StatusBits-1:0]       status_ff, status_in;
   logic [DATA_WIDTH-1:0]       rd_ff, rd_in;
   logic [DATA_WIDTH-1:0]       front_ff, front_in;
   logic [DATA_WIDTH-1:0]       back_ff, back_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RspDataBits-1:0]      rsp_data_ff, rsp_data_in;

   // Result fields at their port widths.
   logic [DATA_WIDTH+31:0]      rd_ext, front_ext, back_ext;
   logic [CNT_WIDTH+CountBits-1:0] count_ext;

   assign req_position = req_tdata[PosBits-1:0];
   assign req_value    = req_tdata[PosBits+ValueBits-1:PosBits];
   assign value_ext    = {{DATA_WIDTH{1'b0}}, req_value};
   assign cell_value   = value_ext[DATA_WIDTH-1:0];
   assign pos_wide     = {{CNT_WIDTH{1'b0}}, req_position};
   assign count_wide   = {{PosBits{1'b0}}, count_ff};

   assign req_tready = (state_ff == SEQ_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Request checks against the current element count.
   always_comb begin
      dec_status = STATUS_OK;
      dec_op     = CELL_HOLD;
      dec_pos    = pos_wide[CNT_WIDTH-1:0];
      dec_count  = count_ff;
      dec_read   = 1'b0;
      case (req_tuser)
         MODE_PUSH_BACK: begin
            if (count_ff == Cap) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_op    = CELL_WRITE;
               dec_pos   = count_ff;
               dec_count = count_ff + CNT_WIDTH'(1);
            end
         end
         MODE_PUSH_FRONT: begin
            if (count_ff == Cap) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_op    = CELL_INSERT;
               dec_pos   = '0;
               dec_count = count_ff + CNT_WIDTH'(1);
            end
         end
         MODE_INSERT: begin
            if (pos_wide > count_wide) begin
               dec_status = STATUS_RANGE;
            end else if (count_ff == Cap) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_op    = CELL_INSERT;
               dec_count = count_ff + CNT_WIDTH'(1);
            end
         end
         MODE_POP_BACK: begin
            if (count_ff == '0) begin
               dec_status = STATUS_EMPTY;
            end else begin
               dec_count = count_ff - CNT_WIDTH'(1);
            end
         end
         MODE_POP_FRONT: begin
            if (count_ff == '0) begin
               dec_status = STATUS_EMPTY;
            end else begin
               dec_op    = CELL_REMOVE;
               dec_pos   = '0;
               dec_count = count_ff - CNT_WIDTH'(1);
            end
         end
         MODE_REMOVE: begin
            if (pos_wide >= count_wide) begin
               dec_status = STATUS_RANGE;
            end else begin
               dec_op    = CELL_REMOVE;
               dec_count = count_ff - CNT_WIDTH'(1);
            end
         end
         MODE_READ: begin
            if (pos_wide >= count_wide) begin
               dec_status = STATUS_RANGE;
            end else begin
               dec_read = 1'b1;
            end
         end
         MODE_WRITE: begin
            if (pos_wide >= count_wide) begin
               dec_status = STATUS_RANGE;
            end else begin
               dec_op = CELL_WRITE;
            end
         end
         MODE_CLEAR: begin
            dec_count = '0;
         end
         default: begin
            dec_status = STATUS_OK;
         end
      endcase
   end

   // Cell chain control: update on accept, walk the taps during the sweep.
   always_comb begin
      cell_ctrl.op    = accept ? dec_op : CELL_HOLD;
      cell_ctrl.load  = accept;
      cell_ctrl.shift = (state_ff == SEQ_SWEEP);
      cell_pos        = dec_pos;
   end

   // Result fields in port widths.
   assign rd_ext    = {32'b0, rd_ff};
   assign front_ext = {32'b0, front_ff};
   assign back_ext  = {32'b0, back_ff};
   assign count_ext = {{CountBits{1'b0}}, count_ff};

   // Sequencer: next state, value capture and output register.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      read_in      = read_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               count_in  = dec_count;
               step_in   = '0;
               last_in   = dec_count - CNT_WIDTH'(1);
               pos_in    = dec_pos;
               read_in   = dec_read;
               status_in = dec_status;
               rd_in     = '0;
               front_in  = '0;
               back_in   = '0;
               state_in  = (dec_count == '0) ? SEQ_DONE : SEQ_SWEEP;
            end
         end
         SEQ_SWEEP: begin
            // The tap at the front holds the element at place step_ff.
            if (step_ff == '0) begin
               front_in = front_tap;
            end
            if (read_ff && (step_ff == pos_ff)) begin
               rd_in = front_tap;
            end
            if (step_ff == last_ff) begin
               back_in  = front_tap;
               state_in = SEQ_DONE;
            end else begin
               step_in = step_ff + CNT_WIDTH'(1);
            end
         end
         SEQ_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, back_ext[31:0], front_ext[31:0],
                               count_ext[CountBits-1:0], status_ff, rd_ext[31:0]};
               state_in     = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      last_ff     <= last_in;
      pos_ff      <= pos_in;
      read_ff     <= read_in;
      status_ff   <= status_in;
      rd_ff       <= rd_in;
      front_ff    <= front_in;
      back_ff     <= back_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hw/rtl/indexed_sequence_list.sv =====
// ----------------------------------------------------------------------------
// indexed_sequence_list: ordered list engine built as a chain of cells
// Push, pop, insert, remove, read, write and clear on a list of up to
// CAPACITY values, one result item for every request item.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one request item: req_tuser carries the mode and
//   req_tdata the position and value. The rsp channel returns one result
//   item with the read value, status, count and front and back values.
//   An accepted request updates every cell of the chain in that same cycle:
//   insert and remove shift all later elements by one place at once. The
//   chain then copies the elements into a readout line that walks toward
//   the front, one place a cycle, until the back element has passed.
//   Once the back element has reached the front, the result is loaded into
//   the output register; a request that leaves the list empty skips the
//   walk. The next request is taken from the cycle after the result is
//   loaded, so the walk of the readout line sets the pace of the items.
//   The result sits in an output register; a new request is accepted while
//   it waits, and a stalled receiver holds that request's result back until
//   the register frees. Reset empties the list and drops any pending result.
// ----------------------------------------------------------------------------
module indexed_sequence_list #(
   parameter int CAPACITY   = isl_pkg::DefaultCapacity,
   parameter int DATA_WIDTH = isl_pkg::DefaultDataWidth
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // position [4:0], value [36:5], zero [39:37]
   input  logic [isl_pkg::ReqDataBits-1:0]  req_tdata,
   // mode [3:0]
   input  logic [isl_pkg::ModeBits-1:0]     req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value [31:0], status [33:32], count [38:34], front_value [70:39],
   // back_value [102:71], zero [103]
   output logic [isl_pkg::RspDataBits-1:0]  rsp_tdata
);
   import isl_pkg::*;

   localparam int CntWidth = $clog2(CAPACITY + 1);

   cell_ctrl_type          cell_ctrl;
   logic [CntWidth-1:0]    cell_pos;
   logic [DATA_WIDTH-1:0]  cell_value;
   logic [DATA_WIDTH-1:0]  data_w [CAPACITY];
   logic [DATA_WIDTH-1:0]  tap_w  [CAPACITY];

   // Decoder and sequencer.
   isl_ctrl #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_WIDTH  (CntWidth)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .front_tap  (tap_w[0]),
      .cell_ctrl  (cell_ctrl),
      .cell_pos   (cell_pos),
      .cell_value (cell_value)
   );

   // Chain of cells, place 0 being the front of the list.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;
      logic [DATA_WIDTH-1:0] right_tap;

      if (i == 0) begin : g_front
         assign left_data = cell_value;
      end else begin : g_inner_left
         assign left_data = data_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_back
         assign right_data = '0;
         assign right_tap  = '0;
      end else begin : g_inner_right
         assign right_data = data_w[i+1];
         assign right_tap  = tap_w[i+1];
      end

      isl_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_WIDTH  (CntWidth),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .pos        (cell_pos),
         .value      (cell_value),
         .left_data  (left_data),
         .right_data (right_data),
         .right_tap  (right_tap),
         .data       (data_w[i]),
         .tap        (tap_w[i])
      );
   end

endmodule

// ===== hw/rtl/isl_checker.sv =====
// ----------------------------------------------------------------------------
// isl_checker: port-level checks of the indexed sequence list
// Watches the result channel for consistency between status, count and the
// front, back and read values, and for a clean result channel after reset.
// ----------------------------------------------------------------------------
module isl_checker #(
   parameter int CAPACITY = isl_pkg::DefaultCapacity
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [isl_pkg::ReqDataBits-1:0]  req_tdata,
   input  logic [isl_pkg::ModeBits-1:0]     req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [isl_pkg::RspDataBits-1:0]  rsp_tdata
);
   import isl_pkg::*;

   // The count field shows the full count only while it fits in five bits.
   localparam logic CountExact = (CAPACITY < 32);

   logic [31:0]           rd_value;
   logic [StatusBits-1:0] status;
   logic [CountBits-1:0]  count;
   logic [31:0]           front_value;
   logic [31:0]           back_value;
   logic                  unused_req;

   assign rd_value    = rsp_tdata[31:0];
   assign status      = rsp_tdata[33:32];
   assign count       = rsp_tdata[38:34];
   assign front_value = rsp_tdata[70:39];
   assign back_value  = rsp_tdata[102:71];
   assign unused_req  = req_tvalid & req_tready & (^req_tdata) & (^req_tuser);

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // Reset drops any pending result.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // An empty list shows zero at both ends.
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && CountExact && (count == '0) |->
         (front_value == '0) && (back_value == '0))
      else $error("empty list reports a front or back value");

   // A pop refused for emptiness leaves an empty list.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && CountExact && (status == STATUS_EMPTY) |-> (count == '0))
      else $error("empty status with elements in the list");

   // Only a successful read returns a value.
   a_read_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rd_value != '0) |-> (status == STATUS_OK))
      else $error("read value on a failed request");

endmodule

bind indexed_sequence_list isl_checker #(
   .CAPACITY (CAPACITY)
) u_isl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
